@@ rtl/bsfn_pkg.sv @@
// Shared constants, types and opcodes of the bitmap set with find-next search.
package bsfn_pkg;

   // Bitmap geometry
   localparam int SET_CAPACITY = 256;
   localparam int WORD_BITS    = 32;
   localparam int BIT_W        = $clog2(WORD_BITS);
   localparam int WORD_COUNT   = (SET_CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int WPTR_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   // Field widths
   localparam int OPC_W = 3;
   localparam int IDX_W = 9;
   localparam int CFG_W = 9;

   // Width that holds both the configured size and the capacity
   localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int WIDX_W = CMP_W - BIT_W;

   // Search result when nothing is found
   localparam logic [IDX_W-1:0] NONE_INDEX = {IDX_W{1'b1}};

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [OPC_W-1:0] {
      OP_TEST      = 3'd0,
      OP_WRITE     = 3'd1,
      OP_CLEAR_ONE = 3'd2,
      OP_CLEAR_ALL = 3'd3,
      OP_FIND_NEXT = 3'd4
   } opcode_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

@@ rtl/bsfn_if.sv @@
// Valid/ready channel interfaces for request and response items.
interface bsfn_req_if;
   import bsfn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic signed [IDX_W-1:0] index;
   logic                    flag;

   modport source (output valid, output opcode, output index, output flag, input ready);
   modport sink   (input valid, input opcode, input index, input flag, output ready);
endinterface

interface bsfn_rsp_if;
   import bsfn_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    is_member;
   logic signed [IDX_W-1:0] next_index;

   modport source (output valid, output is_member, output next_index, input ready);
   modport sink   (input valid, input is_member, input next_index, output ready);
endinterface

@@ rtl/bsfn_datapath.sv @@
// Datapath: membership words, size register, word scanner and result register.
module bsfn_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bsfn_pkg::CFG_W-1:0]       csr_wr_data,
   input  logic [bsfn_pkg::OPC_W-1:0]       req_opcode,
   input  logic signed [bsfn_pkg::IDX_W-1:0] req_index,
   input  logic                             req_flag,
   input  bsfn_pkg::dp_cmd_type             cmd,
   output bsfn_pkg::dp_status_type          status,
   output logic                             rsp_is_member,
   output logic signed [bsfn_pkg::IDX_W-1:0] rsp_next_index
);
   import bsfn_pkg::*;

   word_type             bits_ff [WORD_COUNT];
   logic [CFG_W-1:0]     active_size_ff;
   logic [OPC_W-1:0]     op_ff;
   logic                 flag_ff;
   logic [CMP_W-1:0]     pos_ff;
   logic                 in_range_ff;
   logic                 empty_ff;
   logic [WPTR_W-1:0]    word_ptr_ff;
   logic                 rsp_is_member_ff;
   logic [IDX_W-1:0]     rsp_next_index_ff;

   logic [CMP_W-1:0]     size_eff;
   logic [CMP_W-1:0]     size_m1;
   logic [WIDX_W-1:0]    size_word;
   logic [BIT_W-1:0]     size_bit;
   logic [WIDX_W-1:0]    last_word;

   logic                 idx_neg;
   logic [CMP_W-1:0]     idx_u;
   logic [CMP_W-1:0]     start;
   logic [CMP_W-1:0]     pos_in;
   logic                 in_range_in;
   logic                 empty_in;
   logic [WPTR_W-1:0]    word_ptr_in;

   word_type             cur_word;
   word_type             hi_mask;
   word_type             lo_mask;
   word_type             cand;
   word_type             new_word;
   logic [WIDX_W-1:0]    ptr_ext;
   logic                 hit;
   logic                 at_last;
   logic [BIT_W-1:0]     enc;
   logic [CMP_W-1:0]     found_full;
   logic                 wr_en;
   logic                 member_in;
   logic [IDX_W-1:0]     next_in;

   // Effective size, capped at the capacity
   always_comb begin
      if (CMP_W'(active_size_ff) > CMP_W'(SET_CAPACITY)) begin
         size_eff = CMP_W'(SET_CAPACITY);
      end else begin
         size_eff = CMP_W'(active_size_ff);
      end
      size_m1   = size_eff - CMP_W'(1);
      size_word = size_eff[CMP_W-1:BIT_W];
      size_bit  = size_eff[BIT_W-1:0];
      last_word = size_m1[CMP_W-1:BIT_W];
   end

   // Decode the incoming item for the load
   always_comb begin
      idx_neg     = req_index[IDX_W-1];
      idx_u       = CMP_W'(req_index[IDX_W-2:0]);
      start       = idx_neg ? '0 : idx_u + CMP_W'(1);
      in_range_in = !idx_neg && (idx_u < size_eff);
      if (req_opcode == OP_FIND_NEXT) begin
         pos_in = start;
      end else begin
         pos_in = idx_u;
      end
      if (req_opcode == OP_CLEAR_ALL) begin
         empty_in    = (size_eff == '0);
         word_ptr_in = '0;
      end else begin
         empty_in    = (start >= size_eff);
         word_ptr_in = pos_in[WPTR_W+BIT_W-1:BIT_W];
      end
   end

   // Masks and lowest set bit of the current word
   always_comb begin
      cur_word = bits_ff[word_ptr_ff];
      ptr_ext  = WIDX_W'(word_ptr_ff);
      if (ptr_ext < size_word) begin
         hi_mask = '1;
      end else if (ptr_ext == size_word) begin
         hi_mask = (word_type'(1) << size_bit) - word_type'(1);
      end else begin
         hi_mask = '0;
      end
      if (ptr_ext == pos_ff[CMP_W-1:BIT_W]) begin
         lo_mask = {WORD_BITS{1'b1}} << pos_ff[BIT_W-1:0];
      end else begin
         lo_mask = '1;
      end
      cand    = cur_word & lo_mask & hi_mask;
      hit     = !empty_ff && (|cand);
      at_last = (ptr_ext == last_word);
      enc     = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            enc = BIT_W'(b);
         end
      end
      found_full = CMP_W'({word_ptr_ff, enc});
   end

   // Per-opcode action for one step
   always_comb begin
      status.last = 1'b1;
      wr_en       = 1'b0;
      new_word    = cur_word;
      member_in   = 1'b0;
      next_in     = NONE_INDEX;
      unique case (op_ff)
         OP_TEST: begin
            member_in = in_range_ff && cur_word[pos_ff[BIT_W-1:0]];
         end
         OP_WRITE: begin
            wr_en = in_range_ff;
            new_word[pos_ff[BIT_W-1:0]] = flag_ff;
         end
         OP_CLEAR_ONE: begin
            wr_en = in_range_ff;
            new_word[pos_ff[BIT_W-1:0]] = 1'b0;
         end
         OP_CLEAR_ALL: begin
            status.last = empty_ff || at_last;
            wr_en       = !empty_ff;
            new_word    = cur_word & ~hi_mask;
         end
         OP_FIND_NEXT: begin
            status.last = empty_ff || hit || at_last;
            if (hit) begin
               next_in = found_full[IDX_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Hold size, item context, bitmap and result
   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= '0;
         for (int w = 0; w < WORD_COUNT; w++) begin
            bits_ff[w] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            active_size_ff <= csr_wr_data;
         end
         if (cmd.step && wr_en) begin
            bits_ff[word_ptr_ff] <= new_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_opcode;
         flag_ff     <= req_flag;
         pos_ff      <= pos_in;
         in_range_ff <= in_range_in;
         empty_ff    <= empty_in;
         word_ptr_ff <= word_ptr_in;
      end else if (cmd.step) begin
         word_ptr_ff <= word_ptr_ff + WPTR_W'(1);
      end
      if (cmd.step && status.last) begin
         rsp_is_member_ff  <= member_in;
         rsp_next_index_ff <= next_in;
      end
   end

   assign rsp_is_member  = rsp_is_member_ff;
   assign rsp_next_index = rsp_next_index_ff;

endmodule

@@ rtl/bsfn_ctrl.sv @@
// Controller: accepts an item, steps the datapath and hands over the result.
module bsfn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bsfn_pkg::dp_status_type status,
   output bsfn_pkg::dp_cmd_type    cmd
);
   import bsfn_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // Issue load and step commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      out_free  = !rsp_valid_ff || rsp_ready;
      cmd.load  = req_valid && req_ready;
      cmd.step  = (state_ff == ST_BUSY) && (!status.last || out_free);
   end

   // Advance state, hold the result valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step && status.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (cmd.step && status.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/bitmap_set_find_next_core.sv @@
// Top level of the bitmap set with find-next search.
// A set of up to 256 small integers kept as membership words of 32 bits, all
// cleared by reset. csr_wr_data sets the active size; indices at or above it
// are out of range. Each request item tests, writes or clears one member,
// clears all members below the size, or finds the first member after index
// (-1 starts at 0); every item returns one response item. Timing: an item
// can be taken in the cycle after the previous response is registered, then
// the datapath steps once per 32-bit word, the final step waiting while the
// previous response is still uncollected. Test, write and clear one load and
// take one step; clear all steps through each word up to the size, and takes
// one step at size zero; find next steps through the words from the start
// word up to the hit or the last word in range (one step when the search
// start is already out of range). The single read port on the membership
// words means one word is read per step. The response sits in an output
// register and a request can be taken while it waits to be collected.
module bitmap_set_find_next_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [bsfn_pkg::CFG_W-1:0] csr_wr_data,
   bsfn_req_if.sink                   req_chan,
   bsfn_rsp_if.source                 rsp_chan
);
   import bsfn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   bsfn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsfn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_opcode     (req_chan.opcode),
      .req_index      (req_chan.index),
      .req_flag       (req_chan.flag),
      .cmd            (cmd),
      .status         (status),
      .rsp_is_member  (rsp_chan.is_member),
      .rsp_next_index (rsp_chan.next_index)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

@@ rtl/bsfn_checker.sv @@
// Port-level checks on the bitmap set core, bound to its top level.
module bsfn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_is_member,
   input logic signed [bsfn_pkg::IDX_W-1:0] rsp_next_index
);
   import bsfn_pkg::*;

   logic [1:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Count items taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pending_ff <= pending_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         pending_ff <= pending_ff - 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_is_member) && $stable(rsp_next_index))
      else $error("response payload changed while stalled");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a pending item");

   a_member_no_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_member |-> rsp_next_index == NONE_INDEX)
      else $error("test result carries a search index");

endmodule

bind bitmap_set_find_next_core bsfn_checker u_bsfn_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_is_member  (rsp_chan.is_member),
   .rsp_next_index (rsp_chan.next_index)
);

@@ verif/bitmap_set_find_next_core_tb.sv @@
// Self-checking testbench for the bitmap set core with find-next search.
`timescale 1ns / 100ps

module bitmap_set_find_next_core_tb;
   import bsfn_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int ITEMS_PER_SET = 67;

   localparam logic [OPC_W-1:0]        OP_SPARE_FIRST = 3'd5;
   localparam logic [OPC_W-1:0]        OP_SPARE_MID   = 3'd6;
   localparam logic [OPC_W-1:0]        OP_SPARE_LAST  = 3'd7;
   localparam logic signed [IDX_W-1:0] MINUS_ONE      = -1;
   localparam logic signed [IDX_W-1:0] MOST_NEGATIVE  = -256;

   typedef struct {
      logic                    is_member;
      logic signed [IDX_W-1:0] next_index;
   } lookup_result_type;

   // Predicted membership state plus the queue of lookups still to come back
   class set_scoreboard;
      logic [SET_CAPACITY-1:0] members;
      int unsigned             size_reg;
      lookup_result_type       lookup_q[$];
      int                      errors;

      function new();
         members  = '0;
         size_reg = 0;
         errors   = 0;
      endfunction

      function void write_size(logic [CFG_W-1:0] value);
         size_reg = value;
      endfunction

      function int used_size();
         return (size_reg > SET_CAPACITY) ? SET_CAPACITY : int'(size_reg);
      endfunction

      function int pending();
         return lookup_q.size();
      endfunction

      // Apply one accepted item to the bitmap and queue its result
      function void note_request(logic [OPC_W-1:0] opc, logic signed [IDX_W-1:0] idx,
                                 logic member_flag);
         int                pos;
         int                used;
         bit                in_range;
         lookup_result_type res;
         used     = used_size();
         pos      = idx;
         in_range = (pos >= 0) && (pos < used);
         res.is_member  = 1'b0;
         res.next_index = NONE_INDEX;
         case (opc)
            OP_TEST: begin
               if (in_range) res.is_member = members[pos];
            end
            OP_WRITE: begin
               if (in_range) members[pos] = member_flag;
            end
            OP_CLEAR_ONE: begin
               if (in_range) members[pos] = 1'b0;
            end
            OP_CLEAR_ALL: begin
               for (int b = 0; b < used; b++) members[b] = 1'b0;
            end
            OP_FIND_NEXT: begin
               for (int b = (pos < 0) ? 0 : pos + 1; b < used; b++) begin
                  if (members[b]) begin
                     res.next_index = IDX_W'(b);
                     break;
                  end
               end
            end
            default: ;
         endcase
         lookup_q.insert(lookup_q.size(), res);
      endfunction

      // Compare one collected result with the oldest prediction
      function void check_response(logic is_member, logic signed [IDX_W-1:0] next_index);
         lookup_result_type res;
         if (lookup_q.size() == 0) begin
            $display("%0t: unexpected item is_member=%0b next_index=%0d",
                     $time, is_member, next_index);
            errors++;
            return;
         end
         res = lookup_q.pop_front();
         if (is_member !== res.is_member) begin
            $display("%0t: is_member mismatch expected %0b actual %0b",
                     $time, res.is_member, is_member);
            errors++;
         end
         if (next_index !== res.next_index) begin
            $display("%0t: next_index mismatch expected %0d actual %0d",
                     $time, res.next_index, next_index);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   int               cycle_count = 0;
   int               burst_left  = 0;
   logic [15:0]      stall_pat;
   logic [3:0]       pat_pos = '0;

   bsfn_req_if req_bus ();
   bsfn_rsp_if rsp_bus ();

   set_scoreboard sb = new();

   bitmap_set_find_next_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   // Collect results first, then note newly accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.is_member, rsp_bus.next_index);
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.opcode, req_bus.index, req_bus.flag);
      end
   end

   // Receiver back-pressure: pick a fresh stall pattern each time the 4-bit pattern position wraps
   always @(negedge clock) begin
      if (pat_pos == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'h8000;
         endcase
      end
      rsp_bus.ready = stall_pat[pat_pos];
      pat_pos++;
   end

   // Present one item and hold it until accepted
   task automatic send_item(input logic [OPC_W-1:0] opc, input logic signed [IDX_W-1:0] idx,
                            input logic member_flag);
      req_bus.valid  = 1'b1;
      req_bus.opcode = opc;
      req_bus.index  = idx;
      req_bus.flag   = member_flag;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Drop valid for a random gap at the end of each burst
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      burst_left--;
   endtask

   // Wait until every result has come back and the core has settled
   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [CFG_W-1:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.write_size(value);
   endtask

   // Mostly in-range indices, with edges, -1 and raw 9-bit noise mixed in
   task automatic send_random(input bit sparse);
      logic [OPC_W-1:0]        opc;
      logic signed [IDX_W-1:0] idx;
      logic                    member_flag;
      int                      used;
      int                      pick;
      used = sb.used_size();
      pick = $urandom_range(0, 99);
      if (pick < 20)      opc = OP_TEST;
      else if (pick < 50) opc = OP_WRITE;
      else if (pick < 60) opc = OP_CLEAR_ONE;
      else if (pick < 63) opc = OP_CLEAR_ALL;
      else if (pick < 93) opc = OP_FIND_NEXT;
      else                opc = OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      pick = $urandom_range(0, 9);
      if (used > 0 && pick < 6) idx = IDX_W'($urandom_range(0, used - 1));
      else if (pick == 6)       idx = MINUS_ONE;
      else if (pick == 7)       idx = IDX_W'(used - int'($urandom_range(0, 1)));
      else                      idx = IDX_W'($urandom);
      if (opc == OP_WRITE)
         member_flag = sparse ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 9) < 8);
      else
         member_flag = 1'($urandom);
      pace_sender();
      send_item(opc, idx, member_flag);
   endtask

   initial begin
      logic [CFG_W-1:0] phase_sizes[12];
      phase_sizes = '{256, 1, 0, 33, 32, 511, 64, 255, 257, 100, 2, 31};
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_TEST;
      req_bus.index  = '0;
      req_bus.flag   = 1'b0;
      rsp_bus.ready  = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Size zero after reset: everything is out of range
      send_item(OP_WRITE, 0, 1'b1);
      send_item(OP_FIND_NEXT, MINUS_ONE, 1'b0);

      // Size above capacity acts as full capacity
      write_size(511);
      send_item(OP_WRITE, 0, 1'b1);
      send_item(OP_WRITE, 255, 1'b1);
      send_item(OP_WRITE, 200, 1'b1);
      send_item(OP_TEST, 0, 1'b0);
      send_item(OP_TEST, 255, 1'b0);
      send_item(OP_TEST, MINUS_ONE, 1'b1);
      send_item(OP_FIND_NEXT, MINUS_ONE, 1'b0);
      send_item(OP_FIND_NEXT, 0, 1'b0);
      send_item(OP_FIND_NEXT, 200, 1'b0);
      send_item(OP_FIND_NEXT, 255, 1'b0);
      send_item(OP_FIND_NEXT, MOST_NEGATIVE, 1'b0);
      send_item(OP_CLEAR_ONE, 0, 1'b0);
      send_item(OP_WRITE, 255, 1'b0);
      send_item(OP_TEST, 255, 1'b0);
      send_item(OP_SPARE_FIRST, 200, 1'b1);
      send_item(OP_SPARE_MID, MINUS_ONE, 1'b1);
      send_item(OP_SPARE_LAST, 0, 1'b0);

      // Shrink: bits above the size survive clear all and reappear on growth
      write_size(100);
      send_item(OP_TEST, 200, 1'b0);
      send_item(OP_WRITE, 150, 1'b1);
      send_item(OP_CLEAR_ALL, 0, 1'b0);
      send_item(OP_FIND_NEXT, 99, 1'b0);
      write_size(256);
      send_item(OP_TEST, 200, 1'b0);
      send_item(OP_TEST, 150, 1'b0);
      send_item(OP_FIND_NEXT, 99, 1'b0);

      // Random phases over a spread of sizes, dense and sparse sets
      foreach (phase_sizes[p]) begin
         bit sparse;
         write_size(phase_sizes[p]);
         sparse = 1'($urandom);
         repeat (ITEMS_PER_SET) send_random(sparse);
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0t: %0d errors, %0d items outstanding", $time, sb.errors, sb.pending());
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/bsfn_pkg.sv
rtl/bsfn_if.sv
rtl/bsfn_datapath.sv
rtl/bsfn_ctrl.sv
rtl/bitmap_set_find_next_core.sv
rtl/bsfn_checker.sv
verif/bitmap_set_find_next_core_tb.sv
